[rtl/core/cld_pkg.sv]
// Shared types and constants for the C-LOOK disk scheduler.
`default_nettype none

package cld_pkg;

  // Port widths fixed by the interface
  localparam int unsigned FIELD_W = 12;
  localparam int unsigned SUM_W   = 14;
  localparam logic [SUM_W-1:0] SUM_MAX = 14'h3FFF;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } cld_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic store;        // write accepted request beat
    logic batch_start;  // latch head, clear sum and served marks
    logic scan_start;   // restart the min search
    logic scan_step;    // issue one store read this cycle
    logic emit;         // serve the selected entry, load output register
  } cld_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_done;    // all entries compared, best is final
    logic last_result;  // the next emitted result closes the batch
    logic out_free;     // output register can take a beat this cycle
  } cld_stat_t;

endpackage

`default_nettype wire

[rtl/core/cld_ctrl.sv]
// Controller state machine for the C-LOOK disk scheduler.
`default_nettype none

module cld_ctrl import cld_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      last_request_i,
  output logic           in_stall_o,
  input  wire cld_stat_t stat_i,
  output cld_cmd_t       cmd_o
);

  cld_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (last_request_i) begin
            cmd_o.batch_start = 1'b1;
            cmd_o.scan_start  = 1'b1;
            state_d           = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_result) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cld_dp.sv]
// Datapath: request store, min-key search, head travel and output register.
`default_nettype none

module cld_dp import cld_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 32,
  parameter int unsigned TRACK_BITS   = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cld_cmd_t           cmd_i,
  output cld_stat_t               stat_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [FIELD_W-1:0] head_position_i,
  input  wire logic [FIELD_W-1:0] track_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [FIELD_W-1:0]      served_track_o,
  output logic [FIELD_W-1:0]      move_distance_o,
  output logic [SUM_W-1:0]        total_movement_o,
  output logic                    dropped_requests_o,
  output logic                    last_served_o
);

  localparam int unsigned IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned KEY_W  = TRACK_BITS + 1;
  localparam int unsigned CALC_W = ((SUM_W > TRACK_BITS) ? SUM_W : TRACK_BITS) + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

  logic [TRACK_BITS-1:0] mem_q [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] rd_data_q;

  logic [FIELD_W-1:0]      head_pos_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    overflow_q, overflow_d;
  logic [MAX_REQUESTS-1:0] served_q, served_d;
  logic [CNT_W-1:0]        rd_idx_q, rd_idx_d;
  logic                    p_valid_q, p_valid_d;
  logic [IDX_W-1:0]        p_idx_q, p_idx_d;
  logic                    best_valid_q, best_valid_d;
  logic [KEY_W-1:0]        best_key_q, best_key_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [CNT_W-1:0]        emit_cnt_q, emit_cnt_d;
  logic [TRACK_BITS-1:0]   head_q, head_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic                    out_valid_q, out_valid_d;

  logic                    issue;
  logic                    can_store;
  logic [KEY_W-1:0]        cand_key;
  logic                    take;
  logic [TRACK_BITS-1:0]   sel_track;
  logic [TRACK_BITS-1:0]   move_dist;
  logic [CALC_W-1:0]       sum_ext;
  logic [SUM_W-1:0]        sum_sat;
  logic [CNT_W-1:0]        emit_next;

  assign can_store = count_q < MAX_CNT;
  assign issue     = cmd_i.scan_step && (rd_idx_q < count_q);

  // Tracks below the head sort after everything at or above it
  assign cand_key = {rd_data_q < head_q, rd_data_q};
  assign take     = p_valid_q && !served_q[p_idx_q] &&
                    (!best_valid_q || (cand_key < best_key_q));

  assign sel_track = best_key_q[TRACK_BITS-1:0];
  assign move_dist = (sel_track >= head_q) ? (sel_track - head_q) : (head_q - sel_track);
  assign sum_ext   = CALC_W'(sum_q) + CALC_W'(move_dist);
  assign sum_sat   = (sum_ext > CALC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_ext);
  assign emit_next = emit_cnt_q + CNT_W'(1);

  assign stat_o.scan_done   = (rd_idx_q == count_q) && !p_valid_q;
  assign stat_o.last_result = (emit_next == count_q);
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d      = count_q;
    overflow_d   = overflow_q;
    served_d     = served_q;
    rd_idx_d     = rd_idx_q;
    p_valid_d    = issue;
    p_idx_d      = rd_idx_q[IDX_W-1:0];
    best_valid_d = best_valid_q;
    best_key_d   = best_key_q;
    best_idx_d   = best_idx_q;
    emit_cnt_d   = emit_cnt_q;
    head_d       = head_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cmd_i.store) begin
      if (can_store) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end

    if (cmd_i.batch_start) begin
      head_d     = TRACK_BITS'(head_pos_q);
      sum_d      = '0;
      served_d   = '0;
      emit_cnt_d = '0;
    end

    if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end

    if (take) begin
      best_valid_d = 1'b1;
      best_key_d   = cand_key;
      best_idx_d   = p_idx_q;
    end

    if (cmd_i.emit) begin
      served_d[best_idx_q] = 1'b1;
      head_d      = sel_track;
      sum_d       = sum_sat;
      out_valid_d = 1'b1;
      emit_cnt_d  = emit_next;
      if (stat_o.last_result) begin
        count_d    = '0;
        overflow_d = 1'b0;
        emit_cnt_d = '0;
      end
    end

    if (cmd_i.scan_start) begin
      rd_idx_d     = '0;
      p_valid_d    = 1'b0;
      best_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pos_q   <= '0;
      count_q      <= '0;
      overflow_q   <= 1'b0;
      served_q     <= '0;
      rd_idx_q     <= '0;
      p_valid_q    <= 1'b0;
      best_valid_q <= 1'b0;
      emit_cnt_q   <= '0;
      head_q       <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        head_pos_q <= head_position_i;
      end
      count_q      <= count_d;
      overflow_q   <= overflow_d;
      served_q     <= served_d;
      rd_idx_q     <= rd_idx_d;
      p_valid_q    <= p_valid_d;
      best_valid_q <= best_valid_d;
      emit_cnt_q   <= emit_cnt_d;
      head_q       <= head_d;
      sum_q        <= sum_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Request store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && can_store) begin
      mem_q[count_q[IDX_W-1:0]] <= TRACK_BITS'(track_i);
    end
    rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    p_idx_q    <= p_idx_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    if (cmd_i.emit) begin
      served_track_o     <= FIELD_W'(sel_track);
      move_distance_o    <= FIELD_W'(move_dist);
      total_movement_o   <= sum_sat;
      dropped_requests_o <= overflow_q;
      last_served_o      <= stat_o.last_result;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/c_look_disk_scheduler_unit.sv]
// Top level of the C-LOOK disk scheduler: controller plus datapath.
`default_nettype none

// Channel    Handshake                  Beat contents
// ---------  -------------------------  ---------------------------------------
// cfg        cfg_valid_i / cfg_ready_o  head_position_i
// in         in_valid_i / in_stall_o    track_i, last_request_i
// out        out_valid_o / out_stall_i  served_track_o, move_distance_o,
//                                       total_movement_o, dropped_requests_o,
//                                       last_served_o
//
// Requests load one beat per cycle, while in_stall_o is low, into a request
// store with one write and one read port. For each result the min search
// reads the store once per stored entry, the registered read data drains,
// and the serve step emits the pick. Reset clears all control state; the
// store itself needs no clearing. A stalled output only holds the serve
// step; the next batch loads while the final result of the previous one
// still waits in the output register.

module c_look_disk_scheduler_unit import cld_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 32,
  parameter int unsigned TRACK_BITS   = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration: head start position
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [FIELD_W-1:0] head_position_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [FIELD_W-1:0] track_i,
  input  wire logic               last_request_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [FIELD_W-1:0]      served_track_o,
  output logic [FIELD_W-1:0]      move_distance_o,
  output logic [SUM_W-1:0]        total_movement_o,
  output logic                    dropped_requests_o,
  output logic                    last_served_o
);

  cld_cmd_t  cmd;
  cld_stat_t stat;

  // Register writes must come only while idle (not enforced); always taken
  assign cfg_ready_o = 1'b1;

  cld_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .last_request_i (last_request_i),
    .in_stall_o     (in_stall_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // Serve order is ascending on key {track < head, track}: the upward sweep
  // first, then the wrap to the lowest track and up again.
  cld_dp #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_valid_i        (cfg_valid_i),
    .head_position_i    (head_position_i),
    .track_i            (track_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .served_track_o     (served_track_o),
    .move_distance_o    (move_distance_o),
    .total_movement_o   (total_movement_o),
    .dropped_requests_o (dropped_requests_o),
    .last_served_o      (last_served_o)
  );

endmodule

`default_nettype wire
